>>> design/bspi_pkg.sv
// ----------------------------------------------------------------------------
// bspi_pkg
// shared types, constants and register map of the power indicator block
// ----------------------------------------------------------------------------
package bspi_pkg;

    // field widths
    localparam int NOW_W    = 32;
    localparam int PERIOD_W = 16;
    localparam int HALF_W   = PERIOD_W - 1;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    // sampling and classification constants
    localparam logic [NOW_W-1:0]   SAMPLE_GAP_MS  = 32'd10;
    localparam logic [NOW_W-1:0]   EDGE_WINDOW_MS = 32'd3000;
    localparam logic [COUNT_W-1:0] EDGES_ASLEEP   = 8'd2;
    localparam logic [COUNT_W-1:0] EDGE_MAX       = 8'd255;
    localparam logic [HALF_W-1:0]  MIN_HALF_MS    = 15'd50;

    // status codes
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OFF     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ASLEEP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_AWAKE   = 2'd3;

    // indicator modes
    localparam logic [MODE_W-1:0] DRIVE_DARK   = 2'd0;
    localparam logic [MODE_W-1:0] DRIVE_STEADY = 2'd1;
    localparam logic [MODE_W-1:0] DRIVE_FLASH  = 2'd2;

    // register map
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_SENSE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AWAKE_MODE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SLEEP_MODE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OFF_MODE     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd5;

    // register reset values
    localparam logic                RST_ENABLE       = 1'b1;
    localparam logic                RST_INVERT_SENSE = 1'b0;
    localparam logic [MODE_W-1:0]   RST_AWAKE_MODE   = DRIVE_STEADY;
    localparam logic [MODE_W-1:0]   RST_SLEEP_MODE   = DRIVE_STEADY;
    localparam logic [MODE_W-1:0]   RST_OFF_MODE     = DRIVE_DARK;
    localparam logic [PERIOD_W-1:0] RST_BLINK_PERIOD = 16'd1000;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // divider step counter
    localparam int DIV_CNT_W = $clog2(NOW_W);

    typedef struct packed {
        logic                enable;
        logic                invert_sense;
        logic [MODE_W-1:0]   awake_mode;
        logic [MODE_W-1:0]   sleep_mode;
        logic [MODE_W-1:0]   off_mode;
        logic [PERIOD_W-1:0] blink_period_ms;
    } cfg_t;

    // one classified request: drive is DRIVE_DARK, DRIVE_STEADY or DRIVE_FLASH
    typedef struct packed {
        logic                sampled;
        logic [STATUS_W-1:0] status;
        logic [MODE_W-1:0]   drive;
        logic [NOW_W-1:0]    now_ms;
    } req_t;

    // queue handshake toward the back end
    typedef struct packed {
        logic valid;
        req_t data;
    } queue_out_t;

endpackage

>>> design/bspi_regs.sv
// ----------------------------------------------------------------------------
// bspi_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module bspi_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bspi_pkg::PADDR_W-1:0]      paddr,
    input  logic [bspi_pkg::PDATA_W-1:0]      pwdata,
    output logic [bspi_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    output bspi_pkg::cfg_t                    cfg
);

    bspi_pkg::cfg_t cfg_reg;
    bspi_pkg::cfg_t cfg_next;
    logic [bspi_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[bspi_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                bspi_pkg::REG_ENABLE:       cfg_next.enable       = pwdata[0];
                bspi_pkg::REG_INVERT_SENSE: cfg_next.invert_sense = pwdata[0];
                bspi_pkg::REG_AWAKE_MODE:
                    cfg_next.awake_mode = pwdata[bspi_pkg::MODE_W-1:0];
                bspi_pkg::REG_SLEEP_MODE:
                    cfg_next.sleep_mode = pwdata[bspi_pkg::MODE_W-1:0];
                bspi_pkg::REG_OFF_MODE:
                    cfg_next.off_mode = pwdata[bspi_pkg::MODE_W-1:0];
                bspi_pkg::REG_BLINK_PERIOD:
                    cfg_next.blink_period_ms = pwdata[bspi_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= bspi_pkg::RST_ENABLE;
            cfg_reg.invert_sense    <= bspi_pkg::RST_INVERT_SENSE;
            cfg_reg.awake_mode      <= bspi_pkg::RST_AWAKE_MODE;
            cfg_reg.sleep_mode      <= bspi_pkg::RST_SLEEP_MODE;
            cfg_reg.off_mode        <= bspi_pkg::RST_OFF_MODE;
            cfg_reg.blink_period_ms <= bspi_pkg::RST_BLINK_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            bspi_pkg::REG_ENABLE:       prdata[0] = cfg_reg.enable;
            bspi_pkg::REG_INVERT_SENSE: prdata[0] = cfg_reg.invert_sense;
            bspi_pkg::REG_AWAKE_MODE:
                prdata[bspi_pkg::MODE_W-1:0] = cfg_reg.awake_mode;
            bspi_pkg::REG_SLEEP_MODE:
                prdata[bspi_pkg::MODE_W-1:0] = cfg_reg.sleep_mode;
            bspi_pkg::REG_OFF_MODE:
                prdata[bspi_pkg::MODE_W-1:0] = cfg_reg.off_mode;
            bspi_pkg::REG_BLINK_PERIOD:
                prdata[bspi_pkg::PERIOD_W-1:0] = cfg_reg.blink_period_ms;
            default: prdata = '0;
        endcase
    end

endmodule

>>> design/bspi_front.sv
// ----------------------------------------------------------------------------
// bspi_front
// sample gating, edge counting and status classification
// ----------------------------------------------------------------------------
module bspi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bspi_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bspi_pkg::NOW_W-1:0]    now_ms,
    input  logic                          sense_level,
    output logic                          push,
    input  logic                          push_ready,
    output bspi_pkg::req_t                push_data
);

    logic                            prev_level_reg;
    logic                            prev_level_next;
    logic [bspi_pkg::COUNT_W-1:0]    edge_count_reg;
    logic [bspi_pkg::COUNT_W-1:0]    edge_count_next;
    logic [bspi_pkg::STATUS_W-1:0]   status_reg;
    logic [bspi_pkg::STATUS_W-1:0]   status_next;
    logic [bspi_pkg::NOW_W-1:0]      last_sample_time_reg;
    logic [bspi_pkg::NOW_W-1:0]      last_sample_time_next;
    logic [bspi_pkg::NOW_W-1:0]      last_edge_time_reg;
    logic [bspi_pkg::NOW_W-1:0]      last_edge_time_next;

    logic                            accept;
    logic                            take;
    logic                            level;
    logic                            edge_seen;
    logic [bspi_pkg::NOW_W-1:0]      gap;
    logic [bspi_pkg::NOW_W-1:0]      edge_time;
    logic [bspi_pkg::NOW_W-1:0]      since_edge;
    logic [bspi_pkg::COUNT_W-1:0]    count_step;
    logic [bspi_pkg::COUNT_W-1:0]    count_new;
    logic [bspi_pkg::STATUS_W-1:0]   status_new;
    logic [bspi_pkg::MODE_W-1:0]     mode;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign push     = accept;

    // wrapping gap since last accepted sample
    assign gap  = now_ms - last_sample_time_reg;
    assign take = cfg.enable && (gap >= bspi_pkg::SAMPLE_GAP_MS);

    assign level     = sense_level ^ cfg.invert_sense;
    assign edge_seen = level != prev_level_reg;
    assign edge_time = edge_seen ? now_ms : last_edge_time_reg;

    assign count_step = (edge_seen && (edge_count_reg != bspi_pkg::EDGE_MAX))
                      ? edge_count_reg + 8'd1 : edge_count_reg;
    assign since_edge = now_ms - edge_time;
    assign count_new  = (since_edge > bspi_pkg::EDGE_WINDOW_MS) ? '0 : count_step;

    always_comb
    begin
        if (count_new >= bspi_pkg::EDGES_ASLEEP)
            status_new = bspi_pkg::ST_ASLEEP;
        else if (level)
            status_new = bspi_pkg::ST_AWAKE;
        else
            status_new = bspi_pkg::ST_OFF;
    end

    always_comb
    begin
        if (status_new == bspi_pkg::ST_AWAKE)
            mode = cfg.awake_mode;
        else if (status_new == bspi_pkg::ST_ASLEEP)
            mode = cfg.sleep_mode;
        else
            mode = cfg.off_mode;
    end

    always_comb
    begin
        push_data.sampled = take;
        push_data.status  = take ? status_new : status_reg;
        push_data.now_ms  = now_ms;
        // unused mode code falls back to dark
        if (mode == bspi_pkg::DRIVE_STEADY || mode == bspi_pkg::DRIVE_FLASH)
            push_data.drive = mode;
        else
            push_data.drive = bspi_pkg::DRIVE_DARK;
    end

    always_comb
    begin
        prev_level_next       = prev_level_reg;
        edge_count_next       = edge_count_reg;
        status_next           = status_reg;
        last_sample_time_next = last_sample_time_reg;
        last_edge_time_next   = last_edge_time_reg;
        if (accept && take)
        begin
            prev_level_next       = level;
            edge_count_next       = count_new;
            status_next           = status_new;
            last_sample_time_next = now_ms;
            last_edge_time_next   = edge_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg       <= 1'b0;
            edge_count_reg       <= '0;
            status_reg           <= bspi_pkg::ST_UNKNOWN;
            last_sample_time_reg <= '0;
            last_edge_time_reg   <= '0;
        end
        else
        begin
            prev_level_reg       <= prev_level_next;
            edge_count_reg       <= edge_count_next;
            status_reg           <= status_next;
            last_sample_time_reg <= last_sample_time_next;
            last_edge_time_reg   <= last_edge_time_next;
        end
    end

endmodule

>>> design/bspi_queue.sv
// ----------------------------------------------------------------------------
// bspi_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module bspi_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  push_ready,
    input  bspi_pkg::req_t        push_data,
    output bspi_pkg::queue_out_t  head,
    input  logic                  pop
);

    bspi_pkg::req_t mem [bspi_pkg::QUEUE_DEPTH];

    logic [bspi_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [bspi_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [bspi_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [bspi_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [bspi_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [bspi_pkg::QUEUE_CNT_W-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign push_ready = count_reg != bspi_pkg::QUEUE_CNT_W'(bspi_pkg::QUEUE_DEPTH);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = count_reg != '0;
    assign head.data  = mem[rd_ptr_reg];

    function automatic logic [bspi_pkg::QUEUE_PTR_W-1:0] ptr_inc(
        input logic [bspi_pkg::QUEUE_PTR_W-1:0] ptr
    );
        if (ptr == bspi_pkg::QUEUE_PTR_W'(bspi_pkg::QUEUE_DEPTH - 1))
            return '0;
        return ptr + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/bspi_back.sv
// ----------------------------------------------------------------------------
// bspi_back
// indicator drive: blink phase by a bit-serial divider, result register
// ----------------------------------------------------------------------------
module bspi_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bspi_pkg::cfg_t                    cfg,
    input  bspi_pkg::queue_out_t              head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              sampled,
    output logic [bspi_pkg::STATUS_W-1:0]     pc_status,
    output logic                              indicator_on
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic                             sampled_reg;
    logic                             sampled_next;
    logic [bspi_pkg::STATUS_W-1:0]    status_reg;
    logic [bspi_pkg::STATUS_W-1:0]    status_next;
    logic                             lit_reg;
    logic                             lit_next;
    logic [bspi_pkg::NOW_W-1:0]       dividend_reg;
    logic [bspi_pkg::NOW_W-1:0]       dividend_next;
    logic [bspi_pkg::HALF_W-1:0]      rem_reg;
    logic [bspi_pkg::HALF_W-1:0]      rem_next;
    logic [bspi_pkg::DIV_CNT_W-1:0]   step_reg;
    logic [bspi_pkg::DIV_CNT_W-1:0]   step_next;
    logic                             indicator_reg;
    logic                             indicator_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             out_sampled_reg;
    logic                             out_sampled_next;
    logic [bspi_pkg::STATUS_W-1:0]    out_status_reg;
    logic [bspi_pkg::STATUS_W-1:0]    out_status_next;

    logic [bspi_pkg::HALF_W-1:0]      half_raw;
    logic [bspi_pkg::HALF_W-1:0]      half;
    logic [bspi_pkg::HALF_W:0]        trial;
    logic                             fits;
    logic                             out_free;

    // half period, floored at the minimum
    assign half_raw = cfg.blink_period_ms[bspi_pkg::PERIOD_W-1:1];
    assign half     = (half_raw < bspi_pkg::MIN_HALF_MS) ? bspi_pkg::MIN_HALF_MS : half_raw;

    // one restoring step: shift in the next dividend bit
    assign trial = {rem_reg, dividend_reg[bspi_pkg::NOW_W-1]};
    assign fits  = trial >= {1'b0, half};

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == S_IDLE) && head.valid;

    always_comb
    begin
        state_next       = state_reg;
        sampled_next     = sampled_reg;
        status_next      = status_reg;
        lit_next         = lit_reg;
        dividend_next    = dividend_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        indicator_next   = indicator_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_sampled_next = out_sampled_reg;
        out_status_next  = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    sampled_next  = head.data.sampled;
                    status_next   = head.data.status;
                    lit_next      = head.data.drive == bspi_pkg::DRIVE_STEADY;
                    dividend_next = head.data.now_ms;
                    rem_next      = '0;
                    step_next     = '0;
                    if (head.data.sampled && head.data.drive == bspi_pkg::DRIVE_FLASH)
                        state_next = S_DIV;
                    else
                        state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                dividend_next = {dividend_reg[bspi_pkg::NOW_W-2:0], 1'b0};
                if (fits)
                    rem_next = bspi_pkg::HALF_W'(trial - {1'b0, half});
                else
                    rem_next = trial[bspi_pkg::HALF_W-1:0];
                step_next = step_reg + 1'b1;
                // last quotient bit is the phase: even quotient means lit
                if (step_reg == bspi_pkg::DIV_CNT_W'(bspi_pkg::NOW_W - 1))
                begin
                    lit_next   = !fits;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (sampled_reg)
                        indicator_next = lit_reg;
                    out_valid_next   = 1'b1;
                    out_sampled_next = sampled_reg;
                    out_status_next  = status_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sampled_reg     <= sampled_next;
        status_reg      <= status_next;
        lit_reg         <= lit_next;
        dividend_reg    <= dividend_next;
        rem_reg         <= rem_next;
        step_reg        <= step_next;
        out_sampled_reg <= out_sampled_next;
        out_status_reg  <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            indicator_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            indicator_reg <= indicator_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sampled      = out_sampled_reg;
    assign pc_status    = out_status_reg;
    assign indicator_on = indicator_reg;

endmodule

>>> design/blink_sensing_power_indicator.sv
// ----------------------------------------------------------------------------
// blink_sensing_power_indicator
// senses a power led level, classifies the machine state, drives an indicator
// ----------------------------------------------------------------------------
// every request (now_ms, sense_level) gives exactly one result (sampled,
// pc_status, indicator_on), in order. a request counts as a sample when the
// block is enabled and at least 10 ms passed since the last sample; sampled
// level changes are counted, and two or more within 3000 ms mean asleep,
// else a high level means awake and a low one off. the mode register of that
// state selects dark, solid or blinking; blink phase is now_ms divided by
// half the period (at least 50 ms). timing: the front end takes a request in
// the cycle it arrives while the two-entry queue has room. the back end takes
// one request at a time through its idle and done states; a sampled blinking
// request also runs the one-bit-per-cycle 32-step divider between them; done
// waits while the output register is full and not being read. the output
// register holds a finished result while the next one is worked out.
// configuration registers (apb, byte address 4*i): 0 enable, 1 invert_sense,
// 2 awake_mode, 3 sleep_mode, 4 off_mode, 5 blink_period_ms; write them only
// while no request is outstanding.
// ----------------------------------------------------------------------------
module blink_sensing_power_indicator (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bspi_pkg::PADDR_W-1:0]      paddr,
    input  logic [bspi_pkg::PDATA_W-1:0]      pwdata,
    output logic [bspi_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bspi_pkg::NOW_W-1:0]        now_ms,
    input  logic                              sense_level,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              sampled,
    output logic [bspi_pkg::STATUS_W-1:0]     pc_status,
    output logic                              indicator_on
);

    bspi_pkg::cfg_t       cfg;
    bspi_pkg::req_t       push_data;
    bspi_pkg::queue_out_t head;
    logic                 push;
    logic                 push_ready;
    logic                 pop;

    // register file
    bspi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front end: sample gating, edge count, status
    bspi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now_ms      (now_ms),
        .sense_level (sense_level),
        .push        (push),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // classified requests wait here while the divider runs
    bspi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head       (head),
        .pop        (pop)
    );

    // back end: indicator drive and result register
    bspi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sampled      (sampled),
        .pc_status    (pc_status),
        .indicator_on (indicator_on)
    );

endmodule
